@@ rtl/ica_pkg.sv @@
// Integer calculator ALU: shared package.
// Opcodes, status codes, item tag and control structs, factorial table.
// No dependencies.
package ica_pkg;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_FACT = 3'd4;
  localparam logic [2:0] OP_SQRT = 3'd5;
  localparam logic [2:0] OP_POLL = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DIV_ZERO = 3'd1;
  localparam logic [2:0] ST_FACT_NEG = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_SQRT_NEG = 3'd4;
  localparam logic [2:0] ST_UNKNOWN  = 3'd5;

  localparam int FACT_LIMIT = 20;

  // per-item bookkeeping carried alongside the value
  typedef struct packed {
    logic [2:0]  status;
    logic        slow;
    logic [31:0] id;
  } ica_tag_t;

  // sequencer status towards the top level
  typedef struct packed {
    logic busy;
    logic done;
  } ica_ctl_t;

  function automatic logic [63:0] fact_value(input logic [4:0] idx);
    logic [63:0] v;
    case (idx)
      5'd0:    v = 64'd1;
      5'd1:    v = 64'd1;
      5'd2:    v = 64'd2;
      5'd3:    v = 64'd6;
      5'd4:    v = 64'd24;
      5'd5:    v = 64'd120;
      5'd6:    v = 64'd720;
      5'd7:    v = 64'd5040;
      5'd8:    v = 64'd40320;
      5'd9:    v = 64'd362880;
      5'd10:   v = 64'd3628800;
      5'd11:   v = 64'd39916800;
      5'd12:   v = 64'd479001600;
      5'd13:   v = 64'd6227020800;
      5'd14:   v = 64'd87178291200;
      5'd15:   v = 64'd1307674368000;
      5'd16:   v = 64'd20922789888000;
      5'd17:   v = 64'd355687428096000;
      5'd18:   v = 64'd6402373705728000;
      5'd19:   v = 64'd121645100408832000;
      5'd20:   v = 64'd2432902008176640000;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/ica_addsub.sv @@
// Shared add/subtract unit of the integer calculator.
// Unsigned operands one bit wider than the datapath; top bit of sum is the borrow.
// No dependencies.
module ica_addsub #(
  parameter int W = 64
) (
  input  logic [W:0]   x,
  input  logic [W:0]   y,
  input  logic         sub,
  output logic [W+1:0] s
);

  logic [W+1:0] yx;

  assign yx = {1'b0, y} ^ {(W+2){sub}};
  assign s  = {1'b0, x} + yx + {{(W+1){1'b0}}, sub};

endmodule

@@ rtl/ica_seq.sv @@
// Sequencer and datapath registers of the integer calculator.
// Drives the shared ica_addsub unit: add/subtract, shift-add multiply, restoring divide,
// digit-pair square root. Depends on ica_pkg and ica_addsub.
module ica_seq #(
  parameter int W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        req_type,
  input  logic [W-1:0]      opa,
  input  logic [W-1:0]      opb,
  input  logic [31:0]       req_id,
  input  logic              take,
  output ica_pkg::ica_ctl_t ctl,
  output ica_pkg::ica_tag_t tag,
  output logic [W-1:0]      value
);
  import ica_pkg::*;

  localparam int CW   = $clog2(W);
  localparam int TOPB = ((W - 2) / 2) * 2;
  localparam int ITER = TOPB / 2 + 1;
  localparam logic [63:0] FACT_MAX = (64'd1 << (W - 1)) - 64'd1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ARITH = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ABSA  = 4'd3;
  localparam logic [3:0] S_ABSB  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_NEGQ  = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [2:0]    op_r, op_nxt;
  logic          sa_r, sa_nxt;
  logic          sb_r, sb_nxt;
  ica_tag_t      tag_r, tag_nxt;

  logic [W:0]    ux, uy;
  logic          usub;
  logic [W+1:0]  us;
  logic          borrow;
  logic [63:0]   fact_p;

  ica_addsub #(.W(W)) u_addsub (
    .x   (ux),
    .y   (uy),
    .sub (usub),
    .s   (us)
  );

  assign borrow = us[W+1];
  assign fact_p = fact_value(opa[4:0]);

  // operand selection for the shared unit
  always_comb begin
    ux   = '0;
    uy   = '0;
    usub = 1'b0;
    case (state_r)
      S_ARITH: begin
        ux   = {1'b0, a_r};
        uy   = {1'b0, b_r};
        usub = (op_r == OP_SUB);
      end
      S_MUL: begin
        ux = {1'b0, acc_r};
        uy = {1'b0, a_r & {W{b_r[0]}}};
      end
      S_ABSA, S_NEGQ: begin
        uy   = {1'b0, a_r};
        usub = 1'b1;
      end
      S_ABSB: begin
        uy   = {1'b0, b_r};
        usub = 1'b1;
      end
      S_DIV: begin
        ux   = {acc_r, a_r[W-1]};
        uy   = {1'b0, b_r};
        usub = 1'b1;
      end
      S_SQRT: begin
        ux   = {1'b0, a_r};
        uy   = {1'b0, acc_r | b_r};
        usub = 1'b1;
      end
      default: begin
        ux   = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    op_nxt    = op_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    tag_nxt   = tag_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = req_type;
          a_nxt      = opa;
          b_nxt      = opb;
          acc_nxt    = '0;
          sa_nxt     = opa[W-1];
          sb_nxt     = opb[W-1];
          tag_nxt.id     = req_id;
          tag_nxt.status = ST_OK;
          tag_nxt.slow   = 1'b0;
          state_nxt  = S_DONE;
          case (req_type)
            OP_ADD, OP_SUB: begin
              state_nxt = S_ARITH;
            end
            OP_MUL: begin
              cnt_nxt   = CW'(W - 1);
              state_nxt = S_MUL;
            end
            OP_DIV: begin
              if (opb == '0) begin
                tag_nxt.status = ST_DIV_ZERO;
              end else begin
                state_nxt = S_ABSA;
              end
            end
            OP_FACT: begin
              tag_nxt.slow = 1'b1;
              if (opa[W-1]) begin
                tag_nxt.status = ST_FACT_NEG;
              end else if (opa > W'(FACT_LIMIT)) begin
                tag_nxt.status = ST_OVERFLOW;
              end else if (fact_p > FACT_MAX) begin
                tag_nxt.status = ST_OVERFLOW;
              end else begin
                acc_nxt = fact_p[W-1:0];
              end
            end
            OP_SQRT: begin
              tag_nxt.slow = 1'b1;
              if (opa[W-1]) begin
                tag_nxt.status = ST_SQRT_NEG;
              end else begin
                b_nxt     = W'(1) << TOPB;
                cnt_nxt   = CW'(ITER - 1);
                state_nxt = S_SQRT;
              end
            end
            OP_POLL: begin
              tag_nxt.slow   = 1'b1;
              tag_nxt.status = ST_UNKNOWN;
            end
            default: begin
              tag_nxt.status = ST_UNKNOWN;
            end
          endcase
        end
      end
      S_ARITH: begin
        acc_nxt   = us[W-1:0];
        state_nxt = S_DONE;
      end
      S_MUL: begin
        acc_nxt = us[W-1:0];
        a_nxt   = a_r << 1;
        b_nxt   = b_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_ABSA: begin
        if (sa_r) begin
          a_nxt = us[W-1:0];
        end
        state_nxt = S_ABSB;
      end
      S_ABSB: begin
        if (sb_r) begin
          b_nxt = us[W-1:0];
        end
        acc_nxt   = '0;
        cnt_nxt   = CW'(W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // remainder in acc, dividend shifts out of a while quotient shifts in
        if (!borrow) begin
          acc_nxt = us[W-1:0];
          a_nxt   = {a_r[W-2:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[W-2:0], a_r[W-1]};
          a_nxt   = {a_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_NEGQ;
        end
      end
      S_NEGQ: begin
        acc_nxt   = (sa_r ^ sb_r) ? us[W-1:0] : a_r;
        state_nxt = S_DONE;
      end
      S_SQRT: begin
        // root and bit never overlap, so root + bit is an OR
        if (!borrow) begin
          a_nxt   = us[W-1:0];
          acc_nxt = (acc_r >> 1) | b_r;
        end else begin
          acc_nxt = acc_r >> 1;
        end
        b_nxt   = b_r >> 2;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    op_r  <= op_nxt;
    sa_r  <= sa_nxt;
    sb_r  <= sb_nxt;
    tag_r <= tag_nxt;
  end

  assign ctl.busy = (state_r != S_IDLE);
  assign ctl.done = (state_r == S_DONE);
  assign tag      = tag_r;
  assign value    = acc_r;

endmodule

@@ rtl/integer_calc_alu_unit.sv @@
// Integer calculator ALU, top level: handshakes and output register.
// One item at a time; the next is taken the cycle after the result moves into the
// output register. Multiply, divide and root iterate one step a cycle on the
// shared adder. Synchronous active-low reset clears the sequencer state and count
// and out_valid.
module integer_calc_alu_unit #(
  parameter int OPERAND_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic signed [63:0] in_first_operand,
  input  logic signed [63:0] in_second_operand,
  input  logic [31:0]        in_request_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic               out_slow_class,
  output logic [31:0]        out_echo_id,
  output logic signed [63:0] out_result_value
);
  import ica_pkg::*;

  localparam int W = OPERAND_WIDTH;

  ica_ctl_t              ctl;
  ica_tag_t              core_tag;
  logic [W-1:0]          core_value;
  logic signed [W-1:0]   core_value_s;
  logic                  start;
  logic                  take;

  logic                  out_valid_r, out_valid_nxt;
  ica_tag_t              out_tag_r;
  logic signed [63:0]    out_value_r;

  // busy comes straight from the state register, so stall never looks at valid
  assign in_stall = ctl.busy;
  assign start    = in_valid & ~in_stall;

  ica_seq #(.W(W)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .opa      (in_first_operand[W-1:0]),
    .opb      (in_second_operand[W-1:0]),
    .req_id   (in_request_id),
    .take     (take),
    .ctl      (ctl),
    .tag      (core_tag),
    .value    (core_value)
  );

  // finished item moves on once the output register is empty or being drained
  assign take          = ctl.done & (~out_valid_r | ~out_stall);
  assign out_valid_nxt = take | (out_valid_r & out_stall);
  assign core_value_s  = core_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_tag_r   <= core_tag;
      out_value_r <= 64'(core_value_s);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_tag_r.status;
  assign out_slow_class   = out_tag_r.slow;
  assign out_echo_id      = out_tag_r.id;
  assign out_result_value = out_value_r;

endmodule
